// ----- hw/rtl/rrvs_pkg.sv -----
package rrvs_pkg;

   localparam logic [1:0] FUNC_ATTACH   = 2'd0;
   localparam logic [1:0] FUNC_DETACH   = 2'd1;
   localparam logic [1:0] FUNC_SCHEDULE = 2'd2;

   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_IGNORED = 1'b1;

   localparam logic REG_QUANTUM = 1'b0;
   localparam logic REG_TICKS   = 1'b1;

   localparam logic [7:0]  QUANTUM_RESET = 8'd5;
   localparam logic [31:0] TICKS_RESET   = 32'd1000;

   localparam int SLICE_W = 40;
   localparam logic [SLICE_W-1:0] SLICE_RESET = 40'd5000;

   typedef struct packed {
      logic [1:0]  func;
      logic [2:0]  vcpu_id;
      logic [63:0] time_now;
   } op_type;

   typedef struct packed {
      logic        running_valid;
      logic [2:0]  running_vcpu;
      logic        expiry_valid;
      logic [63:0] expiry_time;
      logic        status;
   } result_type;

endpackage

// ----- hw/rtl/rrvs_core.sv -----
module rrvs_core #(
   parameter int NUM_VCPUS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  rrvs_pkg::op_type              op,
   input  logic [rrvs_pkg::SLICE_W-1:0]  slice_ticks,
   output rrvs_pkg::result_type          result
);
   import rrvs_pkg::*;

   localparam int CW = $clog2(NUM_VCPUS + 1);

   logic [2:0]           q_ff [NUM_VCPUS];
   logic [2:0]           q_in [NUM_VCPUS];
   logic [2:0]           q1   [NUM_VCPUS];
   logic [CW-1:0]        count_ff, count_in, count1;
   logic                 cur_v_ff, cur_v_in;
   logic [2:0]           cur_id_ff, cur_id_in;

   logic [NUM_VCPUS-1:0] live, match, shift, cur_in_q;
   logic [NUM_VCPUS-1:0] ones;
   logic                 found, cur_match, id_ok, full, push;

   always_comb begin
      ones      = '1;
      id_ok     = 32'(op.vcpu_id) < NUM_VCPUS;
      full      = count_ff == CW'(NUM_VCPUS);
      cur_match = cur_v_ff && (cur_id_ff == op.vcpu_id);
      for (int i = 0; i < NUM_VCPUS; i++) begin
         live[i]     = CW'(i) < count_ff;
         match[i]    = live[i] && (q_ff[i] == op.vcpu_id);
         cur_in_q[i] = live[i] && (q_ff[i] == cur_id_ff);
      end
      for (int i = 0; i < NUM_VCPUS; i++) begin
         shift[i] = |(match & (ones >> (NUM_VCPUS - 1 - i)));
      end
      found  = |match;
      push   = cur_v_ff && !full;
      count1 = count_ff + CW'(push);
      for (int i = 0; i < NUM_VCPUS; i++) begin
         q1[i] = (push && (CW'(i) == count_ff)) ? cur_id_ff : q_ff[i];
      end
   end

   always_comb begin
      q_in      = q_ff;
      count_in  = count_ff;
      cur_v_in  = cur_v_ff;
      cur_id_in = cur_id_ff;
      result    = '0;
      result.status = STATUS_DONE;
      case (op.func)
         FUNC_ATTACH: begin
            if (id_ok) begin
               if (cur_match || found || full) begin
                  result.status = STATUS_IGNORED;
               end else begin
                  for (int i = 0; i < NUM_VCPUS; i++) begin
                     if (CW'(i) == count_ff) q_in[i] = op.vcpu_id;
                  end
                  count_in = count_ff + CW'(1);
               end
            end
         end
         FUNC_DETACH: begin
            if (id_ok) begin
               if (found) begin
                  for (int i = 0; i < NUM_VCPUS - 1; i++) begin
                     if (shift[i]) q_in[i] = q_ff[i+1];
                  end
                  count_in = count_ff - CW'(1);
               end
               if (cur_match) begin
                  cur_v_in  = 1'b0;
                  cur_id_in = 3'd0;
               end
            end
         end
         FUNC_SCHEDULE: begin
            if (count1 != '0) begin
               cur_v_in  = 1'b1;
               cur_id_in = q1[0];
               for (int i = 0; i < NUM_VCPUS - 1; i++) begin
                  q_in[i] = q1[i+1];
               end
               q_in[NUM_VCPUS-1]   = q1[NUM_VCPUS-1];
               count_in            = count1 - CW'(1);
               result.expiry_valid = 1'b1;
               result.expiry_time  = op.time_now + 64'(slice_ticks);
            end else begin
               cur_v_in  = 1'b0;
               cur_id_in = 3'd0;
            end
         end
         default: begin
         end
      endcase
      result.running_valid = cur_v_in;
      result.running_vcpu  = cur_v_in ? cur_id_in : 3'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         cur_v_ff  <= 1'b0;
         cur_id_ff <= 3'd0;
      end else if (fire) begin
         count_ff  <= count_in;
         cur_v_ff  <= cur_v_in;
         cur_id_ff <= cur_id_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         q_ff <= q_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(NUM_VCPUS))
      else $error("queue count above depth");

   a_running_not_queued: assert property (@(posedge clock) disable iff (reset)
      cur_v_ff |-> (cur_in_q == '0))
      else $error("running vcpu also in queue");

   a_attach_grows: assert property (@(posedge clock) disable iff (reset)
      (fire && op.func == FUNC_ATTACH && id_ok && result.status == STATUS_DONE)
      |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("accepted attach did not grow the queue");

   a_idle_no_expiry: assert property (@(posedge clock) disable iff (reset)
      (fire && result.expiry_valid) |-> result.running_valid)
      else $error("expiry set with nothing running");
`endif

endmodule

// ----- hw/rtl/round_robin_vcpu_scheduler_top.sv -----
// channel   direction  beat
// req_      in         func, vcpu_id, time_now
// rsp_      out        running_valid, running_vcpu, expiry_valid, expiry_time, status
// csr (apb) in         quantum_msec at 0x0, ticks_per_msec at 0x4
//
// one beat a cycle sustained while rsp_stall stays low; a req_ beat reaches rsp_
// through the input register, then the queue update into the result register
// reset empties the queue, clears the running slot and valid flags and resets the csr registers; no clearing pass
// req_stall rises only while both the input and result registers are full
// and rsp_stall is high
module round_robin_vcpu_scheduler_top #(
   parameter int NUM_VCPUS = 8
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [2:0]  req_vcpu_id,
   input  logic [63:0] req_time_now,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_running_valid,
   output logic [2:0]  rsp_running_vcpu,
   output logic        rsp_expiry_valid,
   output logic [63:0] rsp_expiry_time,
   output logic        rsp_status,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rrvs_pkg::*;

   logic               in_v_ff;
   op_type             op_ff;
   logic               out_v_ff, out_v_in;
   result_type         res_ff, res_core;
   logic               advance;

   logic [7:0]         quantum_ff;
   logic [31:0]        ticks_ff;
   logic [SLICE_W-1:0] slice_ff, slice_in;
   logic               cfg_we, cfg_index;

   // pipeline control
   assign advance   = in_v_ff && (!out_v_ff || !rsp_stall);
   assign req_stall = in_v_ff && out_v_ff && rsp_stall;

   always_comb begin
      out_v_in = out_v_ff;
      if (advance) begin
         out_v_in = 1'b1;
      end else if (!rsp_stall) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
         if (!req_stall) in_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         op_ff.func     <= req_func;
         op_ff.vcpu_id  <= req_vcpu_id;
         op_ff.time_now <= req_time_now;
      end
      if (advance) begin
         res_ff <= res_core;
      end
   end

   rrvs_core #(
      .NUM_VCPUS (NUM_VCPUS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .op          (op_ff),
      .slice_ticks (slice_ff),
      .result      (res_core)
   );

   assign rsp_valid         = out_v_ff;
   assign rsp_running_valid = res_ff.running_valid;
   assign rsp_running_vcpu  = res_ff.running_vcpu;
   assign rsp_expiry_valid  = res_ff.expiry_valid;
   assign rsp_expiry_time   = res_ff.expiry_time;
   assign rsp_status        = res_ff.status;

   // register port; slice length kept as a product alongside the registers
   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite;
   assign cfg_index  = csr_paddr[2];
   assign csr_prdata = (cfg_index == REG_TICKS) ? ticks_ff : {24'd0, quantum_ff};

   always_comb begin
      slice_in = slice_ff;
      if (cfg_we) begin
         if (cfg_index == REG_QUANTUM) begin
            slice_in = SLICE_W'(csr_pwdata[7:0]) * SLICE_W'(ticks_ff);
         end else begin
            slice_in = SLICE_W'(quantum_ff) * SLICE_W'(csr_pwdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= QUANTUM_RESET;
         ticks_ff   <= TICKS_RESET;
         slice_ff   <= SLICE_RESET;
      end else begin
         slice_ff <= slice_in;
         if (cfg_we && cfg_index == REG_QUANTUM) quantum_ff <= csr_pwdata[7:0];
         if (cfg_we && cfg_index == REG_TICKS)   ticks_ff   <= csr_pwdata;
      end
   end

endmodule

// ----- bench/tb_round_robin_vcpu_scheduler_top.sv -----
module tb_round_robin_vcpu_scheduler_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rrvs_pkg::*;

   localparam int NUM_VCPUS = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HOLD_OFF_AT_BEAT = 300;
   localparam logic [2:0] ADDR_QUANTUM = {REG_QUANTUM, 2'b00};
   localparam logic [2:0] ADDR_TICKS   = {REG_TICKS, 2'b00};
   localparam logic [1:0] FUNC_UNUSED  = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = '0;
   logic [2:0]  req_vcpu_id = '0;
   logic [63:0] req_time_now = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_running_valid;
   logic [2:0]  rsp_running_vcpu;
   logic        rsp_expiry_valid;
   logic [63:0] rsp_expiry_time;
   logic        rsp_status;

   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   round_robin_vcpu_scheduler_top #(
      .NUM_VCPUS(NUM_VCPUS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_vcpu_id(req_vcpu_id),
      .req_time_now(req_time_now),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_running_valid(rsp_running_valid),
      .rsp_running_vcpu(rsp_running_vcpu),
      .rsp_expiry_valid(rsp_expiry_valid),
      .rsp_expiry_time(rsp_expiry_time),
      .rsp_status(rsp_status),
      .csr_psel(psel),
      .csr_penable(penable),
      .csr_pwrite(pwrite),
      .csr_paddr(paddr),
      .csr_pwdata(pwdata),
      .csr_prdata(prdata),
      .csr_pready(pready)
   );

   always #5 clock = ~clock;

   // scheduler state as seen from outside
   logic [2:0]  run_queue[$];
   logic        running_valid = 1'b0;
   logic [2:0]  running_id = '0;
   logic [7:0]  quantum_msec = QUANTUM_RESET;
   logic [31:0] ticks_per_msec = TICKS_RESET;

   op_type      pending_ops[$];
   result_type  expected_results[$];
   int          errors = 0;
   int          rsp_beats = 0;
   int          cycle_count = 0;
   bit          no_idle = 1'b0;

   function automatic result_type apply_run_queue_op(input op_type op);
      result_type r;
      int pos;
      r = '0;
      pos = -1;
      for (int i = 0; i < run_queue.size(); i++) begin
         if (pos < 0 && run_queue[i] == op.vcpu_id) pos = i;
      end
      case (op.func)
         FUNC_ATTACH: begin
            if ((running_valid && running_id == op.vcpu_id) || pos >= 0)
               r.status = STATUS_IGNORED;
            else if (run_queue.size() >= NUM_VCPUS)
               r.status = STATUS_IGNORED;
            else
               run_queue.push_back(op.vcpu_id);
         end
         FUNC_DETACH: begin
            if (pos >= 0) run_queue.delete(pos);
            if (running_valid && running_id == op.vcpu_id) begin
               running_valid = 1'b0;
               running_id = '0;
            end
         end
         FUNC_SCHEDULE: begin
            if (running_valid) begin
               if (run_queue.size() < NUM_VCPUS) run_queue.push_back(running_id);
               running_valid = 1'b0;
               running_id = '0;
            end
            if (run_queue.size() > 0) begin
               running_id = run_queue.pop_front();
               running_valid = 1'b1;
               r.expiry_valid = 1'b1;
               r.expiry_time = op.time_now + 64'(quantum_msec) * 64'(ticks_per_msec);
            end
         end
         default: ;
      endcase
      r.running_valid = running_valid;
      r.running_vcpu = running_valid ? running_id : 3'd0;
      return r;
   endfunction

   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [63:0] random_time();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1 << 20));
      if (roll == 1) return 64'($urandom_range(0, 255));
      return {$urandom, $urandom};
   endfunction

   function automatic op_type random_op();
      op_type op;
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 35) op.func = FUNC_ATTACH;
      else if (roll < 75) op.func = FUNC_SCHEDULE;
      else if (roll < 95) op.func = FUNC_DETACH;
      else op.func = FUNC_UNUSED;
      op.vcpu_id = 3'($urandom_range(0, 7));
      op.time_now = random_time();
      return op;
   endfunction

   task automatic push_op(input logic [1:0] func, input logic [2:0] id,
                          input logic [63:0] now);
      op_type op;
      op.func = func;
      op.vcpu_id = id;
      op.time_now = now;
      pending_ops.push_back(op);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h want %h (beat %0d)", what, got, want, rsp_beats);
      errors++;
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data,
                            input logic [31:0] readback);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_QUANTUM) quantum_msec = data[7:0];
      else ticks_per_msec = data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== readback) report_mismatch("csr readback", 64'(prdata), 64'(readback));
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_ops.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input logic [7:0] quantum, input logic [31:0] ticks,
                            input int count, input bit burst);
      csr_write(ADDR_QUANTUM, {24'($urandom), quantum}, 32'(quantum));
      csr_write(ADDR_TICKS, ticks, ticks);
      no_idle = burst;
      for (int i = 0; i < count; i++) pending_ops.push_back(random_op());
      wait_drained();
      no_idle = 1'b0;
   endtask

   // request driver
   always @(posedge clock) begin
      bit fire;
      bit next_valid;
      op_type op;
      int gap_left;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         fire = req_valid && !req_stall;
         next_valid = req_valid;
         if (fire)
            expected_results.push_back(apply_run_queue_op({req_func, req_vcpu_id,
                                                           req_time_now}));
         if (!req_valid || fire) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_ops.size() != 0) begin
               op = pending_ops.pop_front();
               req_func <= op.func;
               req_vcpu_id <= op.vcpu_id;
               req_time_now <= op.time_now;
               next_valid = 1'b1;
               gap_left = idle_length();
            end
         end
         req_valid <= next_valid;
      end
   end

   // result monitor
   always @(posedge clock) begin
      result_type got;
      result_type want;
      int stall_left;
      int hold_left;
      bit hold_done;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_beats++;
            got = {rsp_running_valid, rsp_running_vcpu, rsp_expiry_valid,
                   rsp_expiry_time, rsp_status};
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected beat", 64'(got), 64'd0);
            end else begin
               want = expected_results.pop_front();
               if (got.running_valid !== want.running_valid)
                  report_mismatch("running_valid", 64'(got.running_valid),
                                  64'(want.running_valid));
               if (got.running_vcpu !== want.running_vcpu)
                  report_mismatch("running_vcpu", 64'(got.running_vcpu),
                                  64'(want.running_vcpu));
               if (got.expiry_valid !== want.expiry_valid)
                  report_mismatch("expiry_valid", 64'(got.expiry_valid),
                                  64'(want.expiry_valid));
               if (got.expiry_time !== want.expiry_time)
                  report_mismatch("expiry_time", got.expiry_time, want.expiry_time);
               if (got.status !== want.status)
                  report_mismatch("status", 64'(got.status), 64'(want.status));
            end
         end
         // long hold-off so the input side backs up
         if (!hold_done && rsp_beats >= HOLD_OFF_AT_BEAT) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = idle_length();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset registers in force
      push_op(FUNC_SCHEDULE, 3'd0, 64'd100);
      push_op(FUNC_DETACH, 3'd4, 64'd0);
      push_op(FUNC_ATTACH, 3'd0, 64'd0);
      push_op(FUNC_ATTACH, 3'd0, 64'd0);
      push_op(FUNC_SCHEDULE, 3'd7, 64'd0);
      push_op(FUNC_ATTACH, 3'd0, 64'd1);
      push_op(FUNC_SCHEDULE, 3'd5, 64'hFFFF_FFFF_FFFF_FFFF);
      push_op(FUNC_ATTACH, 3'd7, 64'hFFFF_FFFF_FFFF_F000);
      push_op(FUNC_ATTACH, 3'd3, 64'h5555_5555_5555_5555);
      push_op(FUNC_UNUSED, 3'd2, 64'hAAAA_AAAA_AAAA_AAAA);
      push_op(FUNC_SCHEDULE, 3'd0, 64'h8000_0000_0000_0000);
      push_op(FUNC_SCHEDULE, 3'd0, 64'h7FFF_FFFF_FFFF_FFFF);
      push_op(FUNC_DETACH, 3'd3, 64'd0);
      push_op(FUNC_SCHEDULE, 3'd0, 64'd0);
      for (int i = 1; i < NUM_VCPUS; i++)
         push_op(FUNC_ATTACH, 3'(i), {$urandom, $urandom});
      push_op(FUNC_ATTACH, 3'd7, 64'd0);
      push_op(FUNC_DETACH, 3'd4, 64'd0);
      push_op(FUNC_SCHEDULE, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      wait_drained();

      run_phase(8'd255, 32'hFFFF_FFFF, 200, 1'b0);
      run_phase(8'd1, 32'd1, 200, 1'b0);
      run_phase(8'd0, 32'd1000, 100, 1'b1);
      run_phase(8'd7, 32'd0, 100, 1'b0);
      run_phase(QUANTUM_RESET, TICKS_RESET, 100, 1'b0);
      for (int i = 0; i < 4; i++)
         run_phase(8'($urandom_range(1, 255)), $urandom, 150, i == 2);

      repeat (10) @(posedge clock);
      while (expected_results.size() != 0) begin
         report_mismatch("missing beat", 64'(expected_results[0]), 64'd0);
         void'(expected_results.pop_front());
      end
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
